// ===== rtl/wms_pkg.sv =====
// Shared types and constants for the windowed metric statistics block.
// No dependencies.
package wms_pkg;
    localparam int METRIC_COUNT = 7;
    localparam int MET_W = 3;
    // Ring length of every window; a power of two so means are shifts
    localparam int WINDOW_DEPTH = 64;

    typedef enum logic [3:0] {
        FUNC_TICK  = 4'd7,
        FUNC_CLEAR = 4'd8
    } func_code_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_WALK  = 7'b0000100,
        ST_VAR   = 7'b0001000,
        ST_ROOT  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // Accumulator strobe from the walk sequencer
    typedef struct packed {
        logic         first;
        logic         valid;
        logic [MET_W-1:0] metric;
    } acc_ctl_t;
endpackage

// ===== rtl/wms_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module wms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/wms_isqrt.sv =====
// Bit-serial integer square root of a 128-bit radicand, one result bit a cycle.
// Depends on nothing.
module wms_isqrt (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] radicand,
    output logic         done,
    output logic [63:0]  root
);
    logic [127:0] rem_reg, rem_next;
    logic [127:0] op_reg, op_next;
    logic [63:0]  root_reg, root_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [129:0] trial;
    logic [129:0] rem_sh;

    // Classic restoring digit-by-digit: two radicand bits a step
    always_comb
    begin
        rem_next  = rem_reg;
        op_next   = op_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        rem_sh    = {rem_reg, op_reg[127:126]};
        trial     = {64'd0, root_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            op_next   = radicand;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            op_next = {op_reg[125:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = 128'(rem_sh - trial);
                root_next = {root_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[127:0];
                root_next = {root_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign root = root_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        op_reg   <= op_next;
        root_reg <= root_next;
    end
endmodule

// ===== rtl/wms_accum.sv =====
// Per-metric window accumulators: sums of all metrics, min/max for metrics
// 0 and 1 and sum of squares for metric 1. Depends on wms_pkg.
module wms_accum
    import wms_pkg::*;
(
    input  logic        clk,
    input  acc_ctl_t    ctl,
    input  logic [31:0] sample,
    output logic [63:0] sum_q   [METRIC_COUNT],
    output logic [31:0] min_q   [2],
    output logic [31:0] max_q   [2],
    output logic [95:0] sumsq1_q
);
    localparam int SUM_W = 32 + $clog2(WINDOW_DEPTH) + 1;

    logic [63:0] sq_reg;
    logic        sq_vld_reg;
    logic        sq_first_reg;

    always_ff @(posedge clk)
    begin
        sq_vld_reg   <= ctl.valid && ctl.metric == MET_W'(1);
        sq_first_reg <= ctl.first;
        sq_reg       <= 64'(sample) * 64'(sample);
        if (ctl.valid)
        begin
            if (ctl.first)
            begin
                sum_q[ctl.metric] <= 64'(sample);
            end
            else
            begin
                sum_q[ctl.metric] <= 64'(SUM_W'(sum_q[ctl.metric]) + SUM_W'(sample));
            end
            if (ctl.metric < MET_W'(2))
            begin
                if (ctl.first || sample < min_q[ctl.metric[0]])
                begin
                    min_q[ctl.metric[0]] <= sample;
                end
                if (ctl.first || sample > max_q[ctl.metric[0]])
                begin
                    max_q[ctl.metric[0]] <= sample;
                end
            end
        end
        if (sq_vld_reg)
        begin
            sumsq1_q <= sq_first_reg ? 96'(sq_reg) : sumsq1_q + 96'(sq_reg);
        end
    end
endmodule

// ===== rtl/windowed_metric_statistics.sv =====
// Windowed metric statistics: seven ring windows of Q16.16 samples with a
// report of means, extremes and deviation. Depends on wms_pkg, wms_ram,
// wms_accum and wms_isqrt.
//
// The window length is the power-of-two package constant WINDOW_DEPTH.
// Writes and non-report ticks leave the block idle. A report walks the
// sample RAM one word a cycle, drains the read pipe and forms N*S2-S1^2
// from 32x32 partial products, runs a bit-serial square root and
// registers the result, then raises out_valid. Clear, and the pass that
// follows reset, sweep the RAM with the input stalled. One item is in work
// at a time, and the input stays stalled until the result beat has left.
module windowed_metric_statistics
    import wms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  func,
    input  logic [31:0] value,
    input  logic        report_due,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] mean_rate,
    output logic [31:0] min_rate,
    output logic [31:0] max_rate,
    output logic [31:0] mean_period,
    output logic [31:0] min_period,
    output logic [31:0] max_period,
    output logic [31:0] spread_period,
    output logic [31:0] mean_metric2,
    output logic [31:0] mean_metric3,
    output logic [31:0] mean_metric4,
    output logic [31:0] mean_metric5,
    output logic [31:0] mean_metric6
);
    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int DEPTH  = METRIC_COUNT * WINDOW_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                rd_vld_reg, rd_first_reg;
    logic [MET_W-1:0]    rd_met_reg;
    logic [SLOT_W-1:0]   wslot_reg;
    logic [MET_W-1:0]    wmet_reg;
    logic [2:0]          step_reg, step_next;
    logic                out_valid_reg;
    logic [127:0]        nsq_reg, s1sq_reg, diff_reg;
    logic [63:0]         root_reg;
    logic                sq_start;
    logic                sq_done;
    logic [63:0]         sq_root;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [31:0]         ram_wdata, ram_rdata;

    acc_ctl_t            acc_ctl;
    logic [63:0]         sum_q [METRIC_COUNT];
    logic [31:0]         min_q [2];
    logic [31:0]         max_q [2];
    logic [95:0]         sumsq1_q;

    logic                accept;
    logic                walk_last;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;

    wms_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Address is metric * WINDOW_DEPTH + slot
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(32'(func[MET_W-1:0]) * WINDOW_DEPTH + 32'(slot_reg));
        ram_wdata = value;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = addr_reg;
            ram_wdata = '0;
        end
        else if (accept && func < 4'(METRIC_COUNT))
        begin
            ram_we = 1'b1;
        end
    end
    assign ram_raddr = addr_reg;
    assign walk_last = addr_reg == ADDR_W'(DEPTH - 1);

    always_comb
    begin
        acc_ctl.valid  = rd_vld_reg;
        acc_ctl.first  = rd_first_reg;
        acc_ctl.metric = rd_met_reg;
    end

    wms_accum u_accum (
        .clk      (clk),
        .ctl      (acc_ctl),
        .sample   (ram_rdata),
        .sum_q    (sum_q),
        .min_q    (min_q),
        .max_q    (max_q),
        .sumsq1_q (sumsq1_q)
    );

    // One 32x32 multiplier builds S1^2 over three steps: lo*lo, hi*lo, hi*hi
    assign mul_a = (step_reg == 3'd1) ? sum_q[1][31:0] : sum_q[1][63:32];
    assign mul_b = (step_reg == 3'd3) ? sum_q[1][63:32] : sum_q[1][31:0];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign sq_start = state_reg == ST_VAR && step_reg == 3'd5;

    wms_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (diff_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        addr_next  = addr_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                addr_next = '0;
                step_next = '0;
                if (accept)
                begin
                    if (func == FUNC_CLEAR)
                    begin
                        slot_next  = '0;
                        state_next = ST_CLEAR;
                    end
                    else if (func == FUNC_TICK)
                    begin
                        slot_next = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ?
                                    '0 : slot_reg + SLOT_W'(1);
                        if (report_due)
                        begin
                            state_next = ST_WALK;
                        end
                    end
                end
            end
            ST_CLEAR:
            begin
                addr_next = addr_reg + ADDR_W'(1);
                if (walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (!walk_last)
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
                else
                begin
                    state_next = ST_VAR;
                end
            end
            ST_VAR:
            begin
                // Drain the read pipe, build S1^2, then form N*S2 - S1^2
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sq_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Sweep the RAM to zero before taking the first beat
            state_reg     <= ST_CLEAR;
            slot_reg      <= '0;
            addr_reg      <= '0;
            step_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            addr_reg   <= addr_next;
            step_reg   <= step_next;
            rd_vld_reg <= state_reg == ST_WALK;
            if (state_reg == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk position: metric and slot of the word being read
    always_ff @(posedge clk)
    begin
        if (state_reg != ST_WALK)
        begin
            wmet_reg  <= '0;
            wslot_reg <= '0;
        end
        else if (wslot_reg == SLOT_W'(WINDOW_DEPTH - 1))
        begin
            wslot_reg <= '0;
            wmet_reg  <= wmet_reg + MET_W'(1);
        end
        else
        begin
            wslot_reg <= wslot_reg + SLOT_W'(1);
        end
        rd_met_reg   <= wmet_reg;
        rd_first_reg <= wslot_reg == '0;
        if (state_reg == ST_VAR && step_reg == 3'd1)
        begin
            nsq_reg  <= 128'(sumsq1_q) << SLOT_W;
            s1sq_reg <= 128'(mul_p);
        end
        if (state_reg == ST_VAR && step_reg == 3'd2)
        begin
            s1sq_reg <= s1sq_reg + (128'(mul_p) << 33);
        end
        if (state_reg == ST_VAR && step_reg == 3'd3)
        begin
            s1sq_reg <= s1sq_reg + (128'(mul_p) << 64);
        end
        if (state_reg == ST_VAR && step_reg == 3'd4)
        begin
            diff_reg <= nsq_reg - s1sq_reg;
        end
        if (sq_done)
        begin
            root_reg <= sq_root;
        end
    end

    // Power-of-two window: divides are shifts
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            mean_rate     <= 32'(sum_q[0] >> SLOT_W);
            min_rate      <= min_q[0];
            max_rate      <= max_q[0];
            mean_period   <= 32'(sum_q[1] >> SLOT_W);
            min_period    <= min_q[1];
            max_period    <= max_q[1];
            spread_period <= 32'(root_reg >> SLOT_W);
            mean_metric2  <= 32'(sum_q[2] >> SLOT_W);
            mean_metric3  <= 32'(sum_q[3] >> SLOT_W);
            mean_metric4  <= 32'(sum_q[4] >> SLOT_W);
            mean_metric5  <= 32'(sum_q[5] >> SLOT_W);
            mean_metric6  <= 32'(sum_q[6] >> SLOT_W);
        end
    end
endmodule

// ===== rtl/wms_checker.sv =====
// Port-level checker for windowed_metric_statistics, bound to the top level.
// Depends on the top level's ports only.
module wms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] min_rate,
    input logic [31:0] max_rate,
    input logic [31:0] mean_rate
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mean_rate))
        else $error("result dropped while stalled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_rate <= max_rate)
        else $error("minimum above maximum");

    a_mean_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mean_rate >= min_rate && mean_rate <= max_rate)
        else $error("mean outside extremes");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
endmodule

bind windowed_metric_statistics wms_checker u_wms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .min_rate  (min_rate),
    .max_rate  (max_rate),
    .mean_rate (mean_rate)
);

// ===== dv/windowed_metric_statistics_tb.sv =====
// Self-checking testbench for windowed_metric_statistics: predicts every report beat
// from its own window store and checks all twelve statistics field by field.
// Depends on wms_pkg and the windowed_metric_statistics RTL.
module windowed_metric_statistics_tb;
    import wms_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH;
    localparam int NSTAT = 12;

    typedef logic [31:0] stats_t [NSTAT];
    typedef struct {
        logic [31:0] f [NSTAT];
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  func = '0;
    logic [31:0] value = '0;
    logic        report_due = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] mean_rate, min_rate, max_rate, mean_period, min_period, max_period;
    logic [31:0] spread_period, mean_metric2, mean_metric3, mean_metric4;
    logic [31:0] mean_metric5, mean_metric6;

    logic [31:0] window_mem [METRIC_COUNT][DEPTH];
    int          slot;
    report_t     pending_reports [$];
    int          mismatches = 0;
    int          reports_seen = 0;
    int          items_sent = 0;
    bit          stall_quiet = 1'b0;

    always #5 clk = ~clk;

    windowed_metric_statistics DUT (.*);

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            else
                return $urandom_range(10, 60);
        end
    endfunction

    function automatic logic [31:0] isqrt128(logic [127:0] a);
        logic [63:0] r;
        logic [63:0] t;
        begin
            r = '0;
            for (int b = 63; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if ({64'd0, t} * {64'd0, t} <= a)
                    r = t;
            end
            return 32'(r / DEPTH);
        end
    endfunction

    function automatic report_t compute_report();
        report_t     rep;
        logic [63:0] sum [METRIC_COUNT];
        logic [127:0] sq;
        logic [31:0] lo [2];
        logic [31:0] hi [2];
        logic [31:0] v;
        begin
            sq = '0;
            for (int m = 0; m < METRIC_COUNT; m++)
            begin
                sum[m] = '0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    v = window_mem[m][i];
                    sum[m] += v;
                    if (m < 2)
                    begin
                        if (i == 0 || v < lo[m]) lo[m] = v;
                        if (i == 0 || v > hi[m]) hi[m] = v;
                    end
                    if (m == 1)
                        sq += {96'd0, v} * {96'd0, v};
                end
            end
            rep.f[0] = 32'(sum[0] / DEPTH);
            rep.f[1] = lo[0];
            rep.f[2] = hi[0];
            rep.f[3] = 32'(sum[1] / DEPTH);
            rep.f[4] = lo[1];
            rep.f[5] = hi[1];
            rep.f[6] = isqrt128(sq * DEPTH - {64'd0, sum[1]} * {64'd0, sum[1]});
            for (int m = 2; m < METRIC_COUNT; m++)
                rep.f[5 + m] = 32'(sum[m] / DEPTH);
            return rep;
        end
    endfunction

    // Update the window copy and queue a report where the item makes one.
    function automatic void predict_item(logic [3:0] fn, logic [31:0] val, logic rep);
        begin
            if (fn < METRIC_COUNT)
                window_mem[fn][slot] = val;
            else if (fn == FUNC_CLEAR)
            begin
                foreach (window_mem[m, i]) window_mem[m][i] = '0;
                slot = 0;
            end
            else if (fn == FUNC_TICK)
            begin
                slot = (slot + 1) % DEPTH;
                if (rep)
                    pending_reports.push_back(compute_report());
            end
        end
    endfunction

    // Leave valid high after the accepting edge; the next call with a gap or
    // the end of the run drops it, so it gets one assignment per time step.
    task automatic send_item(logic [3:0] fn, logic [31:0] val, logic rep, int gap);
        begin
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid   <= 1'b1;
            func       <= fn;
            value      <= val;
            report_due <= rep;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            predict_item(fn, val, rep);
            items_sent++;
        end
    endtask

    // Sample just before the edge, so the beat seen is the one the edge takes.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            report_t exp_rep;
            stats_t  got;
            got = '{mean_rate, min_rate, max_rate, mean_period, min_period, max_period,
                    spread_period, mean_metric2, mean_metric3, mean_metric4,
                    mean_metric5, mean_metric6};
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report beat at %0t", $time);
            end
            else
            begin
                exp_rep = pending_reports.pop_front();
                for (int k = 0; k < NSTAT; k++)
                    if (got[k] !== exp_rep.f[k])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("field %0d: expected %h got %h at %0t",
                                     k, exp_rep.f[k], got[k], $time);
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 25) ?
                         1'b1 : (($urandom_range(0, 99) < 3) ? 1'b1 : 1'b0);
    end

    task automatic test_directed();
        begin
            send_item(FUNC_TICK, 32'd0, 1'b1, 0);
            send_item(4'd0, 32'hFFFF_FFFF, 1'b0, 0);
            send_item(4'd1, 32'hFFFF_FFFF, 1'b1, 0);
            send_item(FUNC_TICK, 32'd0, 1'b1, 0);
            for (int m = 0; m < METRIC_COUNT; m++)
                send_item(4'(m), 32'h0001_0000 << m, 1'b1, 1);
            send_item(FUNC_TICK, 32'd0, 1'b0, 0);
            send_item(4'd1, 32'h8000_0000, 1'b0, 0);
            send_item(4'd9, 32'h1234_5678, 1'b1, 0);
            send_item(4'd15, 32'hFFFF_FFFF, 1'b1, 0);
            send_item(FUNC_TICK, 32'd0, 1'b1, 2);
            send_item(FUNC_CLEAR, 32'hFFFF_FFFF, 1'b1, 0);
            send_item(FUNC_TICK, 32'd0, 1'b1, 0);
        end
    endtask

    // Wrap the slot twice with full windows of extreme metric 1 samples.
    task automatic test_full_windows();
        begin
            for (int i = 0; i < 2 * DEPTH + 5; i++)
            begin
                send_item(4'd1, (i % 2) ? 32'hFFFF_FFFF : 32'd0, 1'b0, 0);
                send_item(4'd0, $urandom, 1'b0, 0);
                send_item(FUNC_TICK, 32'd0, (i % 40) == 39, 0);
            end
        end
    endtask

    task automatic test_random();
        logic [3:0]  fn;
        logic [31:0] val;
        int          r;
        begin
            stall_quiet = 1'b0;
            repeat (1200)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    fn = 4'($urandom_range(0, METRIC_COUNT - 1));
                else if (r < 93)
                    fn = FUNC_TICK;
                else if (r < 95)
                    fn = FUNC_CLEAR;
                else
                    fn = 4'($urandom_range(9, 15));
                case ($urandom_range(0, 3))
                    0: val = $urandom_range(0, 3);
                    1: val = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: val = $urandom;
                endcase
                send_item(fn, val, ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0,
                          (items_sent % 200 < 50) ? 0 : pick_gap());
            end
        end
    endtask

    initial
    begin
        foreach (window_mem[m, i]) window_mem[m][i] = '0;
        slot = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_windows();
        test_random();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (7 * DEPTH + 100) @(posedge clk);
        $display("Sent %0d items, checked %0d report beats across writes, ticks, clears",
                 items_sent, reports_seen);
        $display("and ignored codes with random gaps and output stalls.");
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== windowed_metric_statistics.f =====
rtl/wms_pkg.sv
rtl/wms_ram.sv
rtl/wms_isqrt.sv
rtl/wms_accum.sv
rtl/windowed_metric_statistics.sv
rtl/wms_checker.sv
dv/windowed_metric_statistics_tb.sv
